// ===== sv/bitmap_block_allocator_core_assert.svh =====
// Assertion macros shared by the allocator's checker.
// Needs clk_i and rst_ni to be visible where a macro is used.
`ifndef BITMAP_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// Property checked on every rising edge once reset has been released.
`define BBA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Property checked on every rising edge, reset included.
`define BBA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ===== sv/bba_pkg.sv =====
// Shared types and constants of the bitmap block allocator.
// No dependencies; used by bba_word_scan and bitmap_block_allocator_core.
package bba_pkg;

  // Map geometry. One map word covers 32 blocks of 64 bytes.
  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned WORD_SHIFT  = 5;
  localparam int unsigned BIT_W       = 5;
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned BLOCK_SHIFT = 6;

  // A request needs at most 16384 blocks for its size plus one for alignment.
  localparam int unsigned NEED_W = 15;

  // Field widths of a request.
  localparam int unsigned BYTES_W = 20;
  localparam int unsigned ALIGN_W = 6;
  localparam int unsigned PAGES_W = 7;

  localparam logic [PAGES_W-1:0] PAGES_RESET = 7'd64;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE = 1'b1;

  // Request kinds.
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Control sequence of the allocator.
  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_PREP  = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_MARK  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  // Outcome of examining one map word during a first-fit search.
  typedef struct packed {
    logic             hit;        // the run completes inside this word
    logic             carry_hit;  // that run began in an earlier word or at bit 0
    logic [BIT_W-1:0] start_bit;  // start of the run when it began inside the word
    logic             all_free;   // no block of the word is in use
    logic [BIT_W-1:0] tail_len;   // free blocks above the highest used one
  } word_scan_t;

endpackage

// ===== sv/bba_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, with the read data registered.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bba_word_scan.sv =====
// First-fit evaluation of one 32-bit map word against a carried free run.
// Depends on bba_pkg for the word geometry and the result struct.
module bba_word_scan import bba_pkg::*; (
  input  logic [WORD_BITS-1:0] word_i,
  input  logic [NEED_W-1:0]    run_i,
  input  logic [NEED_W-1:0]    need_i,
  output word_scan_t           res_o
);

  localparam logic [WORD_BITS-1:0] ALL_ONES = '1;

  logic [WORD_BITS-1:0] masked [WORD_BITS];
  logic [BIT_W-1:0]     hu     [WORD_BITS];
  logic [NEED_W-1:0]    len    [WORD_BITS];
  logic [WORD_BITS-1:0] pre_free;
  logic [WORD_BITS-1:0] hit;
  logic [BIT_W-1:0]     pos;

  // Index of the highest set bit (zero for an empty vector).
  function automatic logic [BIT_W-1:0] msb_index(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (v[j]) idx = BIT_W'(j);
    end
    return idx;
  endfunction

  // Index of the lowest set bit (zero for an empty vector).
  function automatic logic [BIT_W-1:0] lsb_index(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (v[j]) idx = BIT_W'(j);
    end
    return idx;
  endfunction

  // For every bit position, the length of the free run that ends there and
  // whether that run is long enough. Each position is worked out on its own.
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      masked[i]   = word_i & (ALL_ONES >> (WORD_BITS - 1 - i));
      pre_free[i] = (masked[i] == '0);
      hu[i]       = msb_index(masked[i]);
      if (pre_free[i]) begin
        len[i] = run_i + NEED_W'(i + 1);
      end else begin
        len[i] = NEED_W'(i) - NEED_W'(hu[i]);
      end
      hit[i] = (len[i] >= need_i);
    end
  end

  // The lowest position that completes a run wins.
  assign pos = lsb_index(hit);

  always_comb begin
    res_o.hit       = |hit;
    res_o.carry_hit = pre_free[pos];
    res_o.start_bit = hu[pos] + 1'b1;
    res_o.all_free  = (word_i == '0);
    res_o.tail_len  = BIT_W'(WORD_BITS - 1) - hu[WORD_BITS-1];
  end

endmodule

// ===== sv/bitmap_block_allocator_core.sv =====
// Top level of the bitmap block allocator: control sequence, registers,
// map RAM. Depends on bba_pkg, bba_ram and bba_word_scan.
//
//   channel  direction  handshake                payload
//   cfg      in         cfg_we_i                 cfg_index_i, cfg_wdata_i
//   in       in         in_valid_i / in_stall_o  op_i, request_bytes_i,
//                                                align_bytes_i, release_address_i
//   out      out        out_valid_o / out_stall_i block_address_o, granted_o
//
// The usage map sits in one RAM with a single read and a single write port;
// every step handles one map word per cycle.
// Allocate: PREP, SCAN over the words searched (up to the pool size), MARK over
// the words marked, DONE. Release: PREP, MARK, DONE, or PREP and DONE alone
// when nothing is cleared. After reset a clearing pass writes every map word
// with in_stall_o held high. A result waiting on out_stall_i does not hold off
// the next request; only the following result waits for it.
module bitmap_block_allocator_core import bba_pkg::*; #(
  parameter int unsigned MAP_WORDS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_wdata_i,
  // Request channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 op_i,
  input  logic [BYTES_W-1:0]   request_bytes_i,
  input  logic [ALIGN_W-1:0]   align_bytes_i,
  input  logic [31:0]          release_address_i,
  // Result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [31:0]          block_address_o,
  output logic                 granted_o
);

  localparam int unsigned ADDR_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned WCNT_W = $clog2(MAP_WORDS + 1);
  localparam int unsigned BLK_W  = WCNT_W + WORD_SHIFT;
  localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(MAP_WORDS - 1);

  // Control registers
  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   clr_q, clr_d;
  logic [WCNT_W-1:0]   w_q, w_d;
  logic [ADDR_W-1:0]   mk_rd_q, mk_rd_d;
  logic [ADDR_W-1:0]   mk_wr_q, mk_wr_d;
  logic                mk_more_q, mk_more_d;
  logic                mk_pend_q, mk_pend_d;
  logic                out_valid_q, out_valid_d;
  logic [31:0]         base_q;
  logic [PAGES_W-1:0]  pages_q;

  // Request and result registers
  logic                op_q, op_d;
  logic [NEED_W-1:0]   need_q, need_d;
  logic [31:0]         rel_off_q, rel_off_d;
  logic [NEED_W-1:0]   run_q, run_d;
  logic [BLK_W-1:0]    start_q, start_d;
  logic [BLK_W-1:0]    lo_q, lo_d;
  logic [BLK_W-1:0]    last_q, last_d;
  logic                ok_q, ok_d;
  logic [31:0]         out_addr_q, out_addr_d;
  logic                out_granted_q, out_granted_d;

  // Datapath signals
  logic [NEED_W-1:0]   need_in;
  logic [WCNT_W-1:0]   pool_words;
  logic [WCNT_W-1:0]   w_next;
  logic [BLK_W-1:0]    word_base;
  logic [BLK_W-1:0]    carry_start;
  logic [BLK_W-1:0]    hit_start;
  logic [BLK_W-1:0]    hit_last;
  logic [31:0]         rel_first;
  logic [31:0]         pool_total;
  logic [31:0]         rel_end;
  logic [31:0]         rel_hi;
  logic                rel_empty;
  logic [ADDR_W-1:0]   lo_word;
  logic [ADDR_W-1:0]   last_word;
  logic [WORD_BITS-1:0] mark_mask;
  word_scan_t          scan;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // Blocks for the size, rounded up, plus one when an alignment is asked for
  // (the alignment is always below the block size).
  assign need_in = NEED_W'(({1'b0, request_bytes_i} + (BYTES_W + 1)'(BLOCK_BYTES - 1))
                           >> BLOCK_SHIFT)
                 + NEED_W'(align_bytes_i != '0);

  // Number of map words in the pool.
  always_comb begin
    if (32'(pages_q) > 32'(MAP_WORDS)) begin
      pool_words = WCNT_W'(MAP_WORDS);
    end else begin
      pool_words = WCNT_W'(pages_q);
    end
  end

  // Search bookkeeping: where a run that reaches this word began.
  assign w_next      = w_q + 1'b1;
  assign word_base   = {w_q, {WORD_SHIFT{1'b0}}};
  assign carry_start = (run_q != '0) ? start_q : word_base;
  assign hit_start   = scan.carry_hit ? carry_start : word_base + BLK_W'(scan.start_bit);
  assign hit_last    = hit_start + BLK_W'(need_q) - 1'b1;

  // Release range, clipped at the end of the pool.
  assign rel_first  = 32'(rel_off_q >> BLOCK_SHIFT);
  assign pool_total = 32'(pool_words) << WORD_SHIFT;
  assign rel_end    = rel_first + 32'(need_q);
  assign rel_hi     = (rel_end > pool_total) ? pool_total : rel_end;
  assign rel_empty  = (need_q == '0) || (rel_first >= pool_total);

  // Bits of the word being written back that fall inside the range.
  assign lo_word   = ADDR_W'(lo_q >> WORD_SHIFT);
  assign last_word = ADDR_W'(last_q >> WORD_SHIFT);
  always_comb begin
    mark_mask = '1;
    if (mk_wr_q == lo_word) begin
      mark_mask = mark_mask & ({WORD_BITS{1'b1}} << lo_q[BIT_W-1:0]);
    end
    if (mk_wr_q == last_word) begin
      mark_mask = mark_mask
                & ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - last_q[BIT_W-1:0]));
    end
  end

  // RAM ports: clearing pass and write-back share the write port.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = mk_wr_q;
    ram_wdata = (op_q == OP_ALLOC) ? (ram_rdata | mark_mask) : (ram_rdata & ~mark_mask);
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if (state_q == ST_MARK && mk_pend_q) begin
      ram_we    = 1'b1;
    end
  end

  // The search reads one word ahead; write-back reads the next word of its range.
  always_comb begin
    ram_raddr = '0;
    if (state_q == ST_SCAN) begin
      ram_raddr = ADDR_W'(w_next);
    end else if (state_q == ST_MARK) begin
      ram_raddr = mk_rd_q;
    end
  end

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bba_word_scan u_word_scan (
    .word_i (ram_rdata),
    .run_i  (run_q),
    .need_i (need_q),
    .res_o  (scan)
  );

  // Control sequence.
  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    w_d           = w_q;
    mk_rd_d       = mk_rd_q;
    mk_wr_d       = mk_wr_q;
    mk_more_d     = mk_more_q;
    mk_pend_d     = mk_pend_q;
    op_d          = op_q;
    need_d        = need_q;
    rel_off_d     = rel_off_q;
    run_d         = run_q;
    start_d       = start_q;
    lo_d          = lo_q;
    last_d        = last_q;
    ok_d          = ok_q;
    out_addr_d    = out_addr_q;
    out_granted_d = out_granted_q;
    out_valid_d   = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == LAST_WORD) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          op_d      = op_i;
          need_d    = need_in;
          rel_off_d = release_address_i - base_q;
          state_d   = ST_PREP;
        end
      end

      ST_PREP: begin
        if (op_q == OP_ALLOC) begin
          // Word 0 is read in this cycle.
          w_d     = '0;
          run_d   = '0;
          start_d = '0;
          if (need_q == '0 || pool_words == '0) begin
            ok_d    = 1'b0;
            state_d = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end else begin
          ok_d = 1'b1;
          if (rel_empty) begin
            state_d = ST_DONE;
          end else begin
            lo_d      = BLK_W'(rel_first);
            last_d    = BLK_W'(rel_hi - 32'd1);
            mk_rd_d   = ADDR_W'(rel_first >> WORD_SHIFT);
            mk_more_d = 1'b1;
            mk_pend_d = 1'b0;
            state_d   = ST_MARK;
          end
        end
      end

      ST_SCAN: begin
        if (scan.hit) begin
          lo_d      = hit_start;
          last_d    = hit_last;
          ok_d      = 1'b1;
          mk_rd_d   = ADDR_W'(hit_start >> WORD_SHIFT);
          mk_more_d = 1'b1;
          mk_pend_d = 1'b0;
          state_d   = ST_MARK;
        end else if (w_next == pool_words) begin
          ok_d    = 1'b0;
          state_d = ST_DONE;
        end else begin
          w_d = w_next;
          if (scan.all_free) begin
            run_d   = run_q + NEED_W'(WORD_BITS);
            start_d = carry_start;
          end else begin
            run_d   = NEED_W'(scan.tail_len);
            start_d = word_base + BLK_W'(WORD_BITS) - BLK_W'(scan.tail_len);
          end
        end
      end

      ST_MARK: begin
        // Read word k while word k-1 is written back.
        mk_pend_d = mk_more_q;
        mk_wr_d   = mk_rd_q;
        if (mk_more_q) begin
          mk_more_d = (mk_rd_q != last_word);
          mk_rd_d   = mk_rd_q + 1'b1;
        end
        if (!mk_pend_q && !mk_more_q) begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d   = 1'b1;
          out_granted_d = ok_q;
          if (ok_q && op_q == OP_ALLOC) begin
            out_addr_d = base_q + 32'({lo_q, {BLOCK_SHIFT{1'b0}}});
          end else begin
            out_addr_d = '0;
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      w_q         <= '0;
      mk_rd_q     <= '0;
      mk_wr_q     <= '0;
      mk_more_q   <= 1'b0;
      mk_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      w_q         <= w_d;
      mk_rd_q     <= mk_rd_d;
      mk_wr_q     <= mk_wr_d;
      mk_more_q   <= mk_more_d;
      mk_pend_q   <= mk_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      pages_q <= PAGES_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BASE_ADDRESS: base_q  <= cfg_wdata_i;
        CFG_PAGES_IN_USE: pages_q <= cfg_wdata_i[PAGES_W-1:0];
      endcase
    end
  end

  // Request and result registers.
  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    need_q        <= need_d;
    rel_off_q     <= rel_off_d;
    run_q         <= run_d;
    start_q       <= start_d;
    lo_q          <= lo_d;
    last_q        <= last_d;
    ok_q          <= ok_d;
    out_addr_q    <= out_addr_d;
    out_granted_q <= out_granted_d;
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign block_address_o = out_addr_q;
  assign granted_o       = out_granted_q;

endmodule

// ===== sv/bba_checker.sv =====
// Port-level checks of the bitmap block allocator, bound to its top level.
// Depends on bitmap_block_allocator_core_assert.svh for the assertion macros.
`include "bitmap_block_allocator_core_assert.svh"

module bba_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] block_address_o,
  input logic        granted_o
);

  // A result held back by the receiver keeps its contents.
  `BBA_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(block_address_o) && $stable(granted_o), "result changed while stalled")

  // A refused allocation reports a zero address; releases, always granted, are outside this check.
  `BBA_ASSERT(a_fail_zero, out_valid_o && !granted_o |-> block_address_o == 32'd0, "failed request carries an address")

  // One request at a time: an accepted request closes the input.
  `BBA_ASSERT(a_one_at_a_time, in_valid_i && !in_stall_o |=> in_stall_o, "second request taken while busy")

  // The clearing pass after reset keeps requests out.
  `BBA_ASSERT_ALWAYS(a_clear_after_reset, !rst_ni |=> in_stall_o, "request accepted during map clearing")

endmodule

bind bitmap_block_allocator_core bba_checker u_bba_checker (.*);

// ===== test/tb_bitmap_block_allocator_core.sv =====
// Self-checking testbench for bitmap_block_allocator_core: a directed script,
// then random allocate and release requests checked against a model of the map.
// Depends on bba_pkg and the allocator RTL only.
module tb_bitmap_block_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import bba_pkg::*;

  localparam int unsigned POOL_WORDS      = 64;
  localparam int unsigned POOL_BYTES      = POOL_WORDS * WORD_BITS * BLOCK_BYTES;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned PHASE_REQUESTS  = 147;
  localparam int unsigned HOLD_OFF_CYCLES = 600;
  localparam int unsigned DRAIN_CYCLES    = 200;
  localparam int unsigned N_ROWS          = 31;

  typedef enum logic {
    ROW_REQUEST,
    ROW_CONFIG
  } row_kind_e;

  typedef struct packed {
    logic               op;
    logic [BYTES_W-1:0] nbytes;
    logic [ALIGN_W-1:0] align;
    logic [31:0]        addr;
  } request_t;

  typedef struct packed {
    logic [31:0] addr;
    logic        granted;
  } grant_t;

  // One line of the directed script. On a register write, addr holds the data.
  typedef struct packed {
    row_kind_e            kind;
    logic                 op;
    logic [BYTES_W-1:0]   nbytes;
    logic [ALIGN_W-1:0]   align;
    logic [31:0]          addr;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic                 known;
    logic [31:0]          exp_addr;
    logic                 exp_granted;
  } script_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic                 op;
  logic [BYTES_W-1:0]   request_bytes;
  logic [ALIGN_W-1:0]   align_bytes;
  logic [31:0]          release_address;
  logic                 out_valid;
  logic                 out_stall;
  logic [31:0]          block_address;
  logic                 granted;

  // Model state: the usage map and the two registers.
  logic [WORD_BITS-1:0] usage_map [POOL_WORDS];
  logic [31:0]          pool_base;
  logic [PAGES_W-1:0]   pool_pages;

  grant_t      pending_results [$];
  request_t    live_blocks [$];
  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned n_requests;
  int unsigned n_grants;
  int unsigned n_releases;
  int unsigned n_writes;

  // Directed script. The map starts empty with base 0 and 64 words.
  script_row_t script_rows [N_ROWS] = '{
    // Zero blocks needed, then the first blocks of an empty map.
    '{ROW_REQUEST, OP_ALLOC,   20'd0,      6'd0,  32'h0,         CFG_BASE_ADDRESS,
      1'b1, 32'h0, 1'b0},
    '{ROW_REQUEST, OP_ALLOC,   20'd1,      6'd0,  32'hFFFF_FFFF, CFG_BASE_ADDRESS,
      1'b1, 32'h0, 1'b1},
    '{ROW_REQUEST, OP_ALLOC,   20'd64,     6'd0,  32'h0,         CFG_BASE_ADDRESS,
      1'b1, 32'd64, 1'b1},
    '{ROW_REQUEST, OP_ALLOC,   20'd65,     6'd63, 32'h0,         CFG_BASE_ADDRESS,
      1'b0, 32'h0, 1'b0},
    '{ROW_REQUEST, OP_ALLOC,   20'd0,      6'd1,  32'h0,         CFG_BASE_ADDRESS,
      1'b0, 32'h0, 1'b0},
    // Largest request can never fit.
    '{ROW_REQUEST, OP_ALLOC,   20'hF_FFFF, 6'd63, 32'h0,         CFG_BASE_ADDRESS,
      1'b1, 32'h0, 1'b0},
    // Release, then release the same free block again.
    '{ROW_REQUEST, OP_RELEASE, 20'd64,     6'd0,  32'h0,         CFG_BASE_ADDRESS,
      1'b1, 32'h0, 1'b1},
    '{ROW_REQUEST, OP_RELEASE, 20'd64,     6'd0,  32'h0,         CFG_BASE_ADDRESS,
      1'b1, 32'h0, 1'b1},
    // Release starting beyond the pool, and one clipped at its end.
    '{ROW_REQUEST, OP_RELEASE, 20'hF_FFFF, 6'd63, 32'hFFFF_FFFF, CFG_BASE_ADDRESS,
      1'b1, 32'h0, 1'b1},
    '{ROW_REQUEST, OP_RELEASE, 20'd4096,   6'd0,  32'd131008,    CFG_BASE_ADDRESS,
      1'b1, 32'h0, 1'b1},
    '{ROW_REQUEST, OP_RELEASE, 20'd131072, 6'd0,  32'h0,         CFG_BASE_ADDRESS,
      1'b1, 32'h0, 1'b1},
    // Whole pool in one request, then a full pool.
    '{ROW_REQUEST, OP_ALLOC,   20'd131072, 6'd0,  32'h0,         CFG_BASE_ADDRESS,
      1'b1, 32'h0, 1'b1},
    '{ROW_REQUEST, OP_ALLOC,   20'd1,      6'd0,  32'h0,         CFG_BASE_ADDRESS,
      1'b1, 32'h0, 1'b0},
    // A hole across the first word boundary, then a run that fills it.
    '{ROW_REQUEST, OP_RELEASE, 20'd128,    6'd0,  32'd1984,      CFG_BASE_ADDRESS,
      1'b1, 32'h0, 1'b1},
    '{ROW_REQUEST, OP_ALLOC,   20'd100,    6'd0,  32'h0,         CFG_BASE_ADDRESS,
      1'b0, 32'h0, 1'b0},
    '{ROW_REQUEST, OP_RELEASE, 20'd131072, 6'd0,  32'h0,         CFG_BASE_ADDRESS,
      1'b1, 32'h0, 1'b1},
    // Base near the top of the address space and a one-word pool.
    '{ROW_CONFIG,  OP_ALLOC,   20'd0,      6'd0,  32'hFFFF_FFC0, CFG_BASE_ADDRESS,
      1'b0, 32'h0, 1'b0},
    '{ROW_CONFIG,  OP_ALLOC,   20'd0,      6'd0,  32'd1,         CFG_PAGES_IN_USE,
      1'b0, 32'h0, 1'b0},
    '{ROW_REQUEST, OP_ALLOC,   20'd64,     6'd0,  32'h0,         CFG_BASE_ADDRESS,
      1'b1, 32'hFFFF_FFC0, 1'b1},
    '{ROW_REQUEST, OP_ALLOC,   20'd64,     6'd0,  32'h0,         CFG_BASE_ADDRESS,
      1'b1, 32'h0, 1'b1},
    '{ROW_REQUEST, OP_ALLOC,   20'd1921,   6'd0,  32'h0,         CFG_BASE_ADDRESS,
      1'b1, 32'h0, 1'b0},
    '{ROW_REQUEST, OP_RELEASE, 20'd64,     6'd0,  32'h0,         CFG_BASE_ADDRESS,
      1'b1, 32'h0, 1'b1},
    // Empty pool.
    '{ROW_CONFIG,  OP_ALLOC,   20'd0,      6'd0,  32'd0,         CFG_PAGES_IN_USE,
      1'b0, 32'h0, 1'b0},
    '{ROW_REQUEST, OP_ALLOC,   20'd1,      6'd0,  32'h0,         CFG_BASE_ADDRESS,
      1'b1, 32'h0, 1'b0},
    '{ROW_REQUEST, OP_RELEASE, 20'd64,     6'd0,  32'hFFFF_FFC0, CFG_BASE_ADDRESS,
      1'b1, 32'h0, 1'b1},
    // Oversized page count and an unaligned base.
    '{ROW_CONFIG,  OP_ALLOC,   20'd0,      6'd0,  32'd127,       CFG_PAGES_IN_USE,
      1'b0, 32'h0, 1'b0},
    '{ROW_CONFIG,  OP_ALLOC,   20'd0,      6'd0,  32'h0000_1234, CFG_BASE_ADDRESS,
      1'b0, 32'h0, 1'b0},
    '{ROW_REQUEST, OP_ALLOC,   20'd64,     6'd0,  32'h0,         CFG_BASE_ADDRESS,
      1'b0, 32'h0, 1'b0},
    // Release below the base wraps to a block far beyond the pool.
    '{ROW_REQUEST, OP_RELEASE, 20'd64,     6'd0,  32'h0000_1233, CFG_BASE_ADDRESS,
      1'b1, 32'h0, 1'b1},
    '{ROW_REQUEST, OP_ALLOC,   20'd1,      6'd0,  32'h0,         CFG_BASE_ADDRESS,
      1'b0, 32'h0, 1'b0},
    '{ROW_REQUEST, OP_RELEASE, 20'd131072, 6'd0,  32'h0000_1234, CFG_BASE_ADDRESS,
      1'b1, 32'h0, 1'b1}
  };

  bitmap_block_allocator_core #(
    .MAP_WORDS(POOL_WORDS)
  ) i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .op_i             (op),
    .request_bytes_i  (request_bytes),
    .align_bytes_i    (align_bytes),
    .release_address_i(release_address),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .block_address_o  (block_address),
    .granted_o        (granted)
  );

  function automatic request_t make_request(input logic r_op, input logic [BYTES_W-1:0] r_bytes,
                                            input logic [ALIGN_W-1:0] r_align,
                                            input logic [31:0] r_addr);
    request_t r;
    r.op     = r_op;
    r.nbytes = r_bytes;
    r.align  = r_align;
    r.addr   = r_addr;
    return r;
  endfunction

  // Blocks covered by a request: its size rounded up, plus one for any alignment.
  function automatic int unsigned blocks_for(input request_t r);
    int unsigned n;
    n = (32'(r.nbytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
    if ((32'(r.align) % BLOCK_BYTES) != 0) begin
      n++;
    end
    return n;
  endfunction

  // First-fit allocate or release on the model map; returns the expected result.
  function automatic grant_t apply_to_map(input request_t r);
    int unsigned need;
    int unsigned total;
    int unsigned run;
    int unsigned start;
    int unsigned first;
    grant_t      g;
    need  = blocks_for(r);
    total = ((pool_pages > POOL_WORDS) ? POOL_WORDS : 32'(pool_pages)) * WORD_BITS;
    g     = '0;
    run   = 0;
    start = 0;
    if (r.op == OP_ALLOC) begin
      if (need == 0) begin
        return g;
      end
      for (int unsigned b = 0; b < total && run < need; b++) begin
        if (!usage_map[b / WORD_BITS][b % WORD_BITS]) begin
          if (run == 0) begin
            start = b;
          end
          run++;
        end else begin
          run = 0;
        end
      end
      if (run < need) begin
        return g;
      end
      for (int unsigned b = start; b < start + need; b++) begin
        usage_map[b / WORD_BITS][b % WORD_BITS] = 1'b1;
      end
      g.addr    = pool_base + start * BLOCK_BYTES;
      g.granted = 1'b1;
    end else begin
      first = (r.addr - pool_base) / BLOCK_BYTES;
      for (int unsigned k = 0; k < need; k++) begin
        if (first + k >= total || first + k < first) begin
          break;
        end
        usage_map[(first + k) / WORD_BITS][(first + k) % WORD_BITS] = 1'b0;
      end
      g.granted = 1'b1;
    end
    return g;
  endfunction

  // Mostly allocations of modest size and releases of live regions, some noise.
  function automatic request_t next_random_request();
    int unsigned        pick;
    int unsigned        size_sel;
    int unsigned        idx;
    logic [BYTES_W-1:0] nbytes;
    logic [ALIGN_W-1:0] align;
    request_t           r;
    pick     = $urandom_range(0, 99);
    size_sel = $urandom_range(0, 99);
    if (size_sel < 60) begin
      nbytes = $urandom_range(1, 256);
    end else if (size_sel < 85) begin
      nbytes = $urandom_range(257, 4096);
    end else if (size_sel < 95) begin
      nbytes = $urandom_range(4097, 65536);
    end else begin
      nbytes = $urandom_range(0, 2**BYTES_W - 1);
    end
    align = ($urandom_range(0, 1) != 0) ? ALIGN_W'($urandom_range(0, 63)) : '0;
    if (pick >= 55 && pick < 88 && live_blocks.size() != 0) begin
      // Give back a live region, pointing anywhere inside its first block.
      idx = $urandom_range(0, live_blocks.size() - 1);
      r   = live_blocks[idx];
      live_blocks.delete(idx);
      r.op   = OP_RELEASE;
      r.addr = r.addr + $urandom_range(0, BLOCK_BYTES - 1);
    end else if (pick >= 88) begin
      case ($urandom_range(0, 2))
        0: begin
          r = make_request(OP_RELEASE, nbytes, align, $urandom());
        end
        1: begin
          r = make_request(OP_RELEASE, nbytes, align,
                           pool_base + $urandom_range(0, POOL_BYTES - 1));
        end
        default: begin
          r = make_request(OP_ALLOC, '0, '0, $urandom());
        end
      endcase
    end else begin
      r = make_request(OP_ALLOC, nbytes, align, $urandom());
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
  endtask

  // Offers one request and waits for it to be taken. Valid is left high.
  task automatic send_request(input request_t r, input logic known, input grant_t typed);
    grant_t   g;
    request_t held;
    in_valid        <= 1'b1;
    op              <= r.op;
    request_bytes   <= r.nbytes;
    align_bytes     <= r.align;
    release_address <= r.addr;
    do @(posedge clk); while (in_stall);
    g = apply_to_map(r);
    pending_results.push_back(known ? typed : g);
    n_requests++;
    if (r.op == OP_RELEASE) begin
      n_releases++;
    end else if (g.granted) begin
      n_grants++;
      held      = r;
      held.addr = g.addr;
      live_blocks.push_back(held);
    end
  endtask

  task automatic wait_until_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BASE_ADDRESS) begin
      pool_base = data;
    end else begin
      pool_pages = data[PAGES_W-1:0];
    end
    n_writes++;
    @(posedge clk);
  endtask

  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: stretches of free flow, light and heavy stalling, and one long hold-off.
  initial begin : result_sink
    int unsigned stretch;
    int unsigned mode;
    bit          held_off;
    stretch   = 0;
    mode      = 0;
    held_off  = 1'b0;
    out_stall <= 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (stretch == 0) begin
        if (!held_off && results_checked >= 60) begin
          held_off = 1'b1;
          mode     = 4;
          stretch  = HOLD_OFF_CYCLES;
        end else begin
          mode    = $urandom_range(0, 3);
          stretch = $urandom_range(5, 80);
        end
      end
      stretch--;
      case (mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 1) == 0);
        3:       out_stall <= ($urandom_range(0, 7) != 0);
        default: out_stall <= 1'b1;
      endcase
    end
  end

  // Each result taken is compared with the oldest outstanding expectation.
  always @(posedge clk) begin : result_check
    grant_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %h/%b with no request outstanding",
                                  block_address, granted));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (granted !== want.granted) begin
          report_mismatch($sformatf("result %0d: granted %b, expected %b",
                                    results_checked, granted, want.granted));
        end
        if (block_address !== want.addr) begin
          report_mismatch($sformatf("result %0d: block_address %h, expected %h",
                                    results_checked, block_address, want.addr));
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned burst;
    logic [31:0] next_base;
    grant_t      typed;
    for (int unsigned w = 0; w < POOL_WORDS; w++) begin
      usage_map[w] = '0;
    end
    pool_base       = '0;
    pool_pages      = PAGES_RESET;
    mismatches      = 0;
    results_checked = 0;
    n_requests      = 0;
    n_grants        = 0;
    n_releases      = 0;
    n_writes        = 0;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_BASE_ADDRESS;
    cfg_wdata       <= '0;
    in_valid        <= 1'b0;
    op              <= OP_ALLOC;
    request_bytes   <= '0;
    align_bytes     <= '0;
    release_address <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed script.
    foreach (script_rows[i]) begin
      if (script_rows[i].kind == ROW_CONFIG) begin
        wait_until_idle();
        write_reg(script_rows[i].reg_idx, script_rows[i].addr);
      end else begin
        typed.addr    = script_rows[i].exp_addr;
        typed.granted = script_rows[i].exp_granted;
        send_request(make_request(script_rows[i].op, script_rows[i].nbytes,
                                  script_rows[i].align, script_rows[i].addr),
                     script_rows[i].known, typed);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
    end

    // Random part: a new base and page count per phase, each starting from an empty map.
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0:       next_base = '0;
        1:       next_base = 32'hFFFF_F000;
        2:       next_base = $urandom() & ~32'(BLOCK_BYTES - 1);
        default: next_base = $urandom();
      endcase
      wait_until_idle();
      write_reg(CFG_BASE_ADDRESS, next_base);
      if (p == 0) begin
        write_reg(CFG_PAGES_IN_USE, 32'd1);
      end else if (p == 1) begin
        write_reg(CFG_PAGES_IN_USE, 32'd64);
      end else begin
        write_reg(CFG_PAGES_IN_USE, $urandom_range(1, 64));
      end
      live_blocks.delete();
      send_request(make_request(OP_RELEASE, BYTES_W'(POOL_BYTES), '0, pool_base), 1'b0, '0);
      burst = $urandom_range(1, 30);
      for (int unsigned i = 0; i < PHASE_REQUESTS; i++) begin
        send_request(next_random_request(), 1'b0, '0);
        burst--;
        if (burst == 0 || i == PHASE_REQUESTS - 1) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 40)) @(posedge clk);
          burst = $urandom_range(1, 30);
        end
      end
    end

    // Let the last results come back, then watch for stray ones.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d requests: %0d granted allocations, %0d releases, %0d register writes.",
             n_requests, n_grants, n_releases, n_writes);
    $display("Random part covered %0d pool settings, with a %0d-cycle result hold-off.",
             RANDOM_PHASES, HOLD_OFF_CYCLES);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
